### rtl/core/wav1d_pkg.sv
// Shared constants, types and codes of the 1D wave stencil unit.
`timescale 1ns / 1ps

package wav1d_pkg;

	// Grid and number formats.
	localparam int LAST_POINT = 1023;
	localparam int ROW_LEN    = LAST_POINT + 1;
	localparam int POINT_W    = 10;
	localparam int SAMPLE_W   = 24;
	localparam int C2_W       = 16;
	localparam int FRAC_W     = 15;

	// Intermediate widths of the stencil arithmetic.
	localparam int LAP_W  = SAMPLE_W + 3;
	localparam int BASE_W = SAMPLE_W + 2;
	localparam int PROD_W = C2_W + 1 + LAP_W;
	localparam int RND_W  = PROD_W - FRAC_W;
	localparam int SUM_W  = RND_W + 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [POINT_W-1:0]  point_t;
	typedef logic        [C2_W-1:0]     c2_t;
	typedef logic signed [LAP_W-1:0]    lap_t;
	typedef logic signed [BASE_W-1:0]   base_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [RND_W-1:0]    rnd_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// Item modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	localparam c2_t     C2_RESET   = 16'd531;
	localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
	localparam sample_t SAMPLE_MIN = -24'sh800000;
	localparam prod_t   ROUND_HALF = prod_t'(1 << (FRAC_W - 1));

	// One accepted item with its place in the grid.
	typedef struct packed {
		logic    mode;
		sample_t value;
		point_t  point;
		logic    last;
		logic    swap;
	} item_t;

	// Registered read data of one bank: the sample at x and at x+1.
	typedef struct packed {
		sample_t at_x;
		sample_t at_next;
	} bank_rd_t;

	// Write port of one bank.
	typedef struct packed {
		logic    en;
		point_t  addr;
		sample_t data;
	} bank_wr_t;

	// Write-back request from the stencil pipeline.
	typedef struct packed {
		logic    en;
		logic    mode;
		logic    swap;
		point_t  point;
		sample_t data;
	} wb_req_t;

endpackage

### rtl/core/wav1d_if.sv
// Handshake channels of the 1D wave stencil unit: samples, results and configuration.
`timescale 1ns / 1ps

interface wav1d_sample_if;
	logic                 valid;
	logic                 ready;
	logic                 mode;
	wav1d_pkg::sample_t   value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface wav1d_result_if;
	logic                 valid;
	logic                 ready;
	wav1d_pkg::sample_t   displacement;
	wav1d_pkg::point_t    position;
	logic                 last_of_row;

	modport source (output valid, output displacement, output position, output last_of_row,
		input ready);
	modport sink (input valid, input displacement, input position, input last_of_row,
		output ready);
endinterface

interface wav1d_cfg_if;
	logic                 valid;
	logic                 ready;
	wav1d_pkg::c2_t       courant_sq;

	modport source (output valid, output courant_sq, input ready);
	modport sink (input valid, input courant_sq, output ready);
endinterface

### rtl/core/wav1d_bank.sv
// One row bank: a sample memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module wav1d_bank (
	input  logic                clk,
	input  wav1d_pkg::bank_wr_t wr,
	input  logic                rd_en,
	input  wav1d_pkg::point_t   rd_addr_a,
	input  wav1d_pkg::point_t   rd_addr_b,
	output wav1d_pkg::bank_rd_t rd
);
	import wav1d_pkg::*;

	sample_t mem_q [ROW_LEN];
	sample_t rd_a_q;
	sample_t rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Read ports; the data holds until the next item is accepted.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd.at_x    = rd_a_q;
	assign rd.at_next = rd_b_q;

endmodule

### rtl/core/wav1d_stencil.sv
// Stencil pipeline: Laplacian and product, then rounding, sum and saturation, then the result register.
`timescale 1ns / 1ps

module wav1d_stencil (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  wav1d_pkg::item_t    item,
	input  wav1d_pkg::c2_t      courant_sq,
	input  wav1d_pkg::bank_rd_t rd0,
	input  wav1d_pkg::bank_rd_t rd1,
	output logic                in_ready,
	output wav1d_pkg::wb_req_t  wb,
	wav1d_result_if.source      results
);
	import wav1d_pkg::*;

	// Stage 1: the accepted item.
	logic    valid_s1;
	item_t   item_s1;

	// Left neighbour of the point in stage 1, as this row leaves it.
	sample_t left_q;

	// Stage 2: product and base term.
	logic    valid_s2;
	logic    mode_s2;
	logic    swap_s2;
	logic    left_end_s2;
	logic    last_s2;
	point_t  point_s2;
	sample_t value_s2;
	prod_t   prod_s2;
	base_t   base_s2;

	// Result register.
	logic    out_valid_q;
	sample_t disp_q;
	point_t  pos_q;
	logic    last_q;

	logic    adv_out;
	logic    ready_s2;
	logic    ready_s1;
	bank_rd_t cur_rd;
	bank_rd_t old_rd;
	sample_t mid;
	lap_t    lap;
	base_t   base;
	logic signed [C2_W:0] c2_s;
	prod_t   prod;
	prod_t   prod_rnd;
	rnd_t    rnd;
	sum_t    sum;
	sample_t step_val;
	sample_t result;

	// Stall chain: a stage moves on when the stage after it is empty or moving.
	assign adv_out  = !out_valid_q || results.ready;
	assign ready_s2 = !valid_s2 || adv_out;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Bank roles follow the row parity captured with the item.
	assign cur_rd = item_s1.swap ? rd1 : rd0;
	assign old_rd = item_s1.swap ? rd0 : rd1;
	assign mid    = cur_rd.at_x;

	// Laplacian: one-sided reflecting form at the right end.
	always_comb begin
		if (item_s1.last) begin
			lap = (lap_t'(left_q) - lap_t'(mid)) <<< 1;
		end else begin
			lap = lap_t'(cur_rd.at_next) - (lap_t'(mid) <<< 1) + lap_t'(left_q);
		end
	end

	assign base = base_t'(mid) + base_t'(mid) - base_t'(old_rd.at_x);
	assign c2_s = {1'b0, courant_sq};
	assign prod = prod_t'(c2_s) * prod_t'(lap);

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Sliding window: the point leaving stage 1 becomes the next left neighbour.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			left_q <= (item_s1.mode == MODE_LOAD) ? item_s1.value : mid;
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			mode_s2     <= item_s1.mode;
			swap_s2     <= item_s1.swap;
			left_end_s2 <= (item_s1.point == '0);
			last_s2     <= item_s1.last;
			point_s2    <= item_s1.point;
			value_s2    <= item_s1.value;
			prod_s2     <= prod;
			base_s2     <= base;
		end
	end

	// Round to nearest with ties upward, add and saturate.
	assign prod_rnd = prod_s2 + ROUND_HALF;
	assign rnd      = $signed(prod_rnd[PROD_W-1:FRAC_W]);
	assign sum      = sum_t'(base_s2) + sum_t'(rnd);

	always_comb begin
		if (sum > sum_t'(SAMPLE_MAX)) begin
			step_val = SAMPLE_MAX;
		end else if (sum < sum_t'(SAMPLE_MIN)) begin
			step_val = SAMPLE_MIN;
		end else begin
			step_val = sample_t'(sum);
		end
	end

	// Loads pass through; a step at the left end is held at zero.
	always_comb begin
		if (mode_s2 == MODE_LOAD) begin
			result = value_s2;
		end else if (left_end_s2) begin
			result = '0;
		end else begin
			result = step_val;
		end
	end

	// Write-back to the banks as the item leaves stage 2.
	assign wb.en    = valid_s2 && adv_out;
	assign wb.mode  = mode_s2;
	assign wb.swap  = swap_s2;
	assign wb.point = point_s2;
	assign wb.data  = result;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			disp_q <= result;
			pos_q  <= point_s2;
			last_q <= last_s2;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.displacement = disp_q;
	assign results.position     = pos_q;
	assign results.last_of_row  = last_q;

endmodule

### rtl/core/wave_1d_leapfrog_stencil_unit.sv
// Top level of the 1D wave stencil unit: point counter, row banks, clearing sweep and pipeline.
`timescale 1ns / 1ps

// Usage.
// Each item on the samples channel is the next grid point of the row, points 0 to
// LAST_POINT in order. A load item (mode 0) stores its value as both the previous and
// the current sample of its point and returns it; a step item (mode 1) returns the new
// leapfrog sample of its point, saturated to signed Q15.8. The left end steps to zero;
// the right end uses the one-sided reflecting form. After the rightmost point the rows
// rotate. Each item gives exactly one item on the results channel, carrying the point
// index and a flag on the rightmost point.
// The cfg channel writes the squared Courant number (unsigned Q1.15); it is always ready
// and should only be written while no item is in flight.
// Throughput is one item per cycle while the receiver takes results, set by the three-sample
// window over the current row and the two read ports on each bank. An accepted item passes
// through stage 1 and stage 2 into the result register.
// After reset both row banks are swept to zero, one address per cycle, from 0 to LAST_POINT;
// samples.ready stays low during the sweep. When the receiver stalls, the pipeline keeps
// filling its empty stages and then holds samples.ready low until a result is taken.

module wave_1d_leapfrog_stencil_unit (
	input  logic            clk,
	input  logic            arst_n,
	wav1d_sample_if.sink    samples,
	wav1d_result_if.source  results,
	wav1d_cfg_if.sink       cfg
);
	import wav1d_pkg::*;

	c2_t      courant_q;
	point_t   point_q;
	logic     swap_q;
	logic     clr_active_q;
	point_t   clr_addr_q;

	logic     pipe_ready;
	logic     accept;
	logic     at_last;
	item_t    item;
	wb_req_t  wb;
	bank_wr_t wr0;
	bank_wr_t wr1;
	bank_rd_t rd0;
	bank_rd_t rd1;
	point_t   next_addr;

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= C2_RESET;
		end else if (cfg.valid) begin
			courant_q <= cfg.courant_sq;
		end
	end

	// Input handshake; no item is taken during the clearing sweep.
	assign samples.ready = pipe_ready && !clr_active_q;
	assign accept        = samples.valid && samples.ready;
	assign at_last       = (point_q == point_t'(LAST_POINT));

	// Point counter and row parity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= '0;
			swap_q  <= 1'b0;
		end else if (accept) begin
			if (at_last) begin
				point_q <= '0;
				swap_q  <= !swap_q;
			end else begin
				point_q <= point_q + 1'b1;
			end
		end
	end

	// Clearing sweep over both banks after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == point_t'(LAST_POINT)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Write steering: the sweep and a load write both banks, a step writes the previous-row bank.
	always_comb begin
		wr0 = '0;
		wr1 = '0;
		if (clr_active_q) begin
			wr0.en   = 1'b1;
			wr0.addr = clr_addr_q;
			wr1.en   = 1'b1;
			wr1.addr = clr_addr_q;
		end else if (wb.en) begin
			wr0.addr = wb.point;
			wr0.data = wb.data;
			wr1.addr = wb.point;
			wr1.data = wb.data;
			if (wb.mode == MODE_LOAD) begin
				wr0.en = 1'b1;
				wr1.en = 1'b1;
			end else begin
				wr0.en = wb.swap;
				wr1.en = !wb.swap;
			end
		end
	end

	// Both banks read the point and its right neighbour for each accepted item.
	assign next_addr = point_q + 1'b1;

	wav1d_bank u_bank0 (
		.clk       (clk),
		.wr        (wr0),
		.rd_en     (accept),
		.rd_addr_a (point_q),
		.rd_addr_b (next_addr),
		.rd        (rd0)
	);

	wav1d_bank u_bank1 (
		.clk       (clk),
		.wr        (wr1),
		.rd_en     (accept),
		.rd_addr_a (point_q),
		.rd_addr_b (next_addr),
		.rd        (rd1)
	);

	// Item as it enters the pipeline.
	assign item.mode  = samples.mode;
	assign item.value = samples.value;
	assign item.point = point_q;
	assign item.last  = at_last;
	assign item.swap  = swap_q;

	wav1d_stencil u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (accept),
		.item       (item),
		.courant_sq (courant_q),
		.rd0        (rd0),
		.rd1        (rd1),
		.in_ready   (pipe_ready),
		.wb         (wb),
		.results    (results)
	);

endmodule
